### hw/rtl/stf_pkg.sv
`timescale 1ns / 1ps

package stf_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_MESSAGE  = 1'b1;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_FWD = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] src_addr;
        logic [15:0] src_port;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic        last;
    } t_out;

    // one stored endpoint
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
    } t_entry;

endpackage

### hw/rtl/stf_table.sv
`timescale 1ns / 1ps

module stf_table #(
    parameter int TABLE_DEPTH = stf_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  stf_pkg::t_entry i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output stf_pkg::t_entry o_rdata
);
    import stf_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    // one write port, one registered read port; read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/subscriber_table_fanout.sv
`timescale 1ns / 1ps

// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_data  (stf_pkg::t_in)
// out      output     o_out_valid / i_out_ready  o_out_data (stf_pkg::t_out)
//
// one item at a time: a message or a register request keeps the input busy
// through its table walk and its finish step; the walk reads one entry per
// cycle, unless a forward stalls it, through the single read port of the
// endpoint memory and one shared endpoint compare
// a synchronous active-low reset empties the table (count and write slot to zero)
// a stalled output freezes the walk only when a new forward must push out the
// held one; the next item is taken while the last result still waits in r_out

module subscriber_table_fanout #(
    parameter int TABLE_DEPTH = stf_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  stf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output stf_pkg::t_out o_out_data
);
    import stf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(TABLE_DEPTH);
    localparam logic [AW-1:0] SLOT_LAST  = AW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state        r_state;
    logic          r_op;
    t_entry        r_src;
    logic [CW-1:0] r_idx;       // next entry to read
    logic          r_rd_vld;    // table read data belongs to a live entry
    logic          r_hold_vld;  // a forward waits to learn whether it is the last
    t_entry        r_hold;
    logic          r_found;     // register source already in table
    logic          r_ack_done;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_slot;
    logic          r_out_vld;
    t_out          r_out;

    t_entry        rd_data;
    logic          rd_match;
    logic          out_free;
    logic          more;
    logic          is_fwd;
    logic          stall;
    logic          rd_en;
    logic          wr_en;

    // shared compare: current table entry against the source endpoint
    assign rd_match = (rd_data == r_src);
    assign out_free = !r_out_vld || i_out_ready;
    assign more     = (r_idx < r_count);
    assign is_fwd   = r_rd_vld && (r_op == OP_MESSAGE) && !rd_match;
    // a new forward must push the held one out, which needs a free output slot
    assign stall    = is_fwd && r_hold_vld && !out_free;
    assign rd_en    = (r_state == S_SCAN) && !stall && more;
    assign wr_en    = (r_state == S_FINISH) && (r_op == OP_REGISTER)
                      && r_ack_done && !r_found;

    stf_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_slot),
        .i_wdata (r_src),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_slot     <= '0;
            r_out_vld  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_found    <= 1'b0;
            r_ack_done <= 1'b0;
            r_idx      <= '0;
        end else begin
            // output register drains on transfer; a push below refills it
            if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op       <= i_in_data.operation;
                        r_src      <= '{addr: i_in_data.src_addr, port: i_in_data.src_port};
                        r_idx      <= '0;
                        r_rd_vld   <= 1'b0;
                        r_hold_vld <= 1'b0;
                        r_found    <= 1'b0;
                        r_ack_done <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // acknowledgement goes out as soon as the output is free
                    if (r_op == OP_REGISTER && !r_ack_done && out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out      <= '{kind: KIND_ACK, dest_addr: r_src.addr,
                                        dest_port: r_src.port, last: 1'b1};
                        r_ack_done <= 1'b1;
                    end
                    if (!stall) begin
                        if (is_fwd) begin
                            if (r_hold_vld) begin
                                r_out_vld <= 1'b1;
                                r_out     <= '{kind: KIND_FWD, dest_addr: r_hold.addr,
                                               dest_port: r_hold.port, last: 1'b0};
                            end
                            r_hold     <= rd_data;
                            r_hold_vld <= 1'b1;
                        end
                        if (r_rd_vld && r_op == OP_REGISTER && rd_match) begin
                            r_found <= 1'b1;
                        end
                        r_rd_vld <= more;
                        if (more) begin
                            r_idx <= r_idx + 1'b1;
                        end else if (!r_rd_vld) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (r_op == OP_MESSAGE) begin
                        // held forward is the final one
                        if (!r_hold_vld) begin
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            r_out_vld  <= 1'b1;
                            r_out      <= '{kind: KIND_FWD, dest_addr: r_hold.addr,
                                            dest_port: r_hold.port, last: 1'b1};
                            r_hold_vld <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end else if (!r_ack_done) begin
                        if (out_free) begin
                            r_out_vld  <= 1'b1;
                            r_out      <= '{kind: KIND_ACK, dest_addr: r_src.addr,
                                            dest_port: r_src.port, last: 1'b1};
                            r_ack_done <= 1'b1;
                        end
                    end else begin
                        // new endpoint written this cycle, oldest replaced when full
                        if (!r_found) begin
                            r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                            if (r_count != COUNT_FULL) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/stf_checker.sv
`timescale 1ns / 1ps

module stf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input stf_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input stf_pkg::t_out o_out_data
);
    import stf_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // one item at a time: no back-to-back input transfers
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // an acknowledgement is always the only result of its item, so it carries last
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_ACK |-> o_out_data.last)
        else $error("acknowledgement without last");

    // nothing can be offered out of reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind subscriber_table_fanout stf_checker u_stf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
